// ===== hw/rtl/lru_page_replacement_macros.svh =====
// Assertion helpers; clk and rst are taken from the scope of the use.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// cons must hold in the same cycle as ante
`define LRU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lru_pkg.sv =====
package lru_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int AGE_W      = 4;
  localparam int FAULT_W    = 16;
  localparam int CFG_W      = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [AGE_W-1:0] AGE_MAX    = '1;
  localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(4);
  localparam logic [CNT_W-1:0] FRAMES_MAX = CNT_W'(MAX_FRAMES);

  // register index, taken from paddr above the byte offset
  localparam logic [APB_ADDR_W-3:0] REG_FRAMES_IN_USE = '0;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } lru_state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     n;
    logic                 hit_fnd;
    logic [IDX_W-1:0]     hit_idx;
    logic [AGE_W-1:0]     hit_age;
    logic                 emp_fnd;
    logic [IDX_W-1:0]     emp_idx;
    logic [AGE_W-1:0]     best_age;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } lru_carry_t;

  // update broadcast to every cell once the search is done
  typedef struct packed {
    logic                 vld;
    logic [IDX_W-1:0]     idx;
    logic [AGE_W-1:0]     age;
    logic                 age_all;
    logic                 fill;
    logic                 wr_page;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     n;
  } lru_upd_t;

endpackage

// ===== hw/rtl/lru_cell.sv =====
module lru_cell import lru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  lru_carry_t       carry_in,
  output lru_carry_t       carry_out,
  input  lru_upd_t         upd
);

  logic [PAGE_BITS-1:0] frame_page;
  logic                 frame_valid;
  logic [AGE_W-1:0]     frame_age;

  lru_carry_t carry_next;
  logic       srch_active;
  logic       upd_active;
  logic       upd_mine;

  assign srch_active = {1'b0, cell_idx} < carry_in.n;
  assign upd_active  = upd.vld && ({1'b0, cell_idx} < upd.n);
  assign upd_mine    = upd.idx == cell_idx;

  always_comb begin
    carry_next = carry_in;
    if (carry_in.vld && srch_active) begin
      if (frame_valid && frame_page == carry_in.page && !carry_in.hit_fnd) begin
        carry_next.hit_fnd = 1'b1;
        carry_next.hit_idx = cell_idx;
        carry_next.hit_age = frame_age;
      end
      if (!frame_valid && !carry_in.emp_fnd) begin
        carry_next.emp_fnd = 1'b1;
        carry_next.emp_idx = cell_idx;
      end
      // oldest frame, first index wins on ties; frame 0 always seeds the pick
      if (cell_idx == '0 || frame_age > carry_in.best_age) begin
        carry_next.best_age  = frame_age;
        carry_next.best_idx  = cell_idx;
        carry_next.best_page = frame_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      frame_age   <= '0;
    end else if (upd_active) begin
      if (upd_mine) begin
        frame_age <= '0;
        if (upd.fill) begin
          frame_valid <= 1'b1;
        end
      end else if (frame_valid && (upd.age_all || frame_age < upd.age) &&
                   frame_age != AGE_MAX) begin
        frame_age <= frame_age + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_active && upd_mine && upd.wr_page) begin
      frame_page <= upd.page;
    end
  end

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------
// item in   | start & !busy          | page_number
// result    | done (one-cycle pulse) | hit, frame_index, evicted_valid,
//           |                        | evicted_page, fault_count
// config    | APB write              | frames_in_use at paddr 0
//
// For each item the seed register takes it, the search token walks the 16
// frame cells one cell per cycle, the decision is registered together with
// done, and the cells apply the update on the edge that also accepts the
// next item. A new item is taken only once the last one is decided.
// rst is synchronous, active high; frame ages, valid marks and the miss
// count clear at once, no clearing pass.
// Results cannot be stalled: done marks them for exactly one cycle.
`include "lru_page_replacement_macros.svh"

module lru_page_replacement import lru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAGE_BITS-1:0]  page_number,
  output logic                  done,
  output logic                  hit,
  output logic [IDX_W-1:0]      frame_index,
  output logic                  evicted_valid,
  output logic [PAGE_BITS-1:0]  evicted_page,
  output logic [FAULT_W-1:0]    fault_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  lru_state_t state, state_next;

  logic [CFG_W-1:0]   frames_in_use;
  logic [FAULT_W-1:0] miss_total;
  logic [FAULT_W-1:0] miss_next;

  lru_carry_t seed, seed_next;
  lru_carry_t chain [MAX_FRAMES];
  lru_carry_t last;
  lru_upd_t   upd, upd_next;

  logic [CNT_W-1:0]      n_active;
  logic                  accept;
  logic                  decide;
  logic [MAX_FRAMES-1:0] tok;
  logic [MAX_FRAMES:0]   all_tok;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[APB_ADDR_W-1:2])
        REG_FRAMES_IN_USE: frames_in_use <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1:2])
      REG_FRAMES_IN_USE: prdata = APB_DATA_W'(frames_in_use);
      default:           prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        busy = 1'b1;
        if (last.vld) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = start && !busy;
  assign decide = (state == ST_SEARCH) && last.vld;

  // clamp the frame count to 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (CNT_W'(frames_in_use) > FRAMES_MAX) begin
      n_active = FRAMES_MAX;
    end else begin
      n_active = CNT_W'(frames_in_use);
    end
  end

  always_comb begin
    seed_next           = '0;
    seed_next.vld       = accept;
    seed_next.page      = page_number;
    seed_next.n         = n_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else begin
      seed <= seed_next;
    end
  end

  // ---------------- cell row ----------------
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_head
      lru_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cell_idx  (IDX_W'(g)),
        .carry_in  (seed),
        .carry_out (chain[g]),
        .upd       (upd)
      );
    end else begin : g_body
      lru_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cell_idx  (IDX_W'(g)),
        .carry_in  (chain[g-1]),
        .carry_out (chain[g]),
        .upd       (upd)
      );
    end
    assign tok[g] = chain[g].vld;
  end

  assign last    = chain[MAX_FRAMES-1];
  assign all_tok = {tok, seed.vld};

  // ---------------- decision ----------------
  always_comb begin
    upd_next      = '0;
    upd_next.vld  = decide;
    upd_next.page = last.page;
    upd_next.n    = last.n;
    if (last.hit_fnd) begin
      upd_next.idx = last.hit_idx;
      upd_next.age = last.hit_age;
    end else if (last.emp_fnd) begin
      upd_next.idx     = last.emp_idx;
      upd_next.age_all = 1'b1;
      upd_next.fill    = 1'b1;
      upd_next.wr_page = 1'b1;
    end else begin
      upd_next.idx     = last.best_idx;
      upd_next.age     = last.best_age;
      upd_next.wr_page = 1'b1;
    end
  end

  assign miss_next = (!last.hit_fnd && miss_total != '1) ? miss_total + 1'b1 : miss_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      upd        <= '0;
      done       <= 1'b0;
      miss_total <= '0;
    end else begin
      upd  <= upd_next;
      done <= decide;
      if (decide) begin
        miss_total <= miss_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      hit           <= last.hit_fnd;
      frame_index   <= upd_next.idx;
      evicted_valid <= !last.hit_fnd && !last.emp_fnd;
      evicted_page  <= (!last.hit_fnd && !last.emp_fnd) ? last.best_page : '0;
    end
  end

  assign fault_count = miss_total;

  // ---------------- checks ----------------
  `LRU_ASSERT_SAME(a_one_token, 1'b1, $onehot0(all_tok), "more than one search token in flight")
  `LRU_ASSERT_SAME(a_hit_no_evict, done && hit, !evicted_valid, "hit reported with an eviction")
  `LRU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `LRU_ASSERT_SAME(a_miss_counted, done && !hit, fault_count != '0, "miss left fault count at zero")

endmodule

// ===== verif/tb_lru_page_replacement.sv =====
`timescale 1ns / 1ps

module tb_lru_page_replacement;
  import lru_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [FAULT_W-1:0]   faults;
  } page_result_t;

  localparam int IDLE_LIMIT  = 600;
  localparam int SETTLE_CYC  = 24;
  localparam int PHASE_ITEMS = 42;
  localparam int MISS_ITEMS  = 40;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [PAGE_BITS-1:0]  page_number;
  logic                  done;
  logic                  hit;
  logic [IDX_W-1:0]      frame_index;
  logic                  evicted_valid;
  logic [PAGE_BITS-1:0]  evicted_page;
  logic [FAULT_W-1:0]    fault_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_page_replacement i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .page_number   (page_number),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // frame table as the block should hold it
  logic [PAGE_BITS-1:0] page_tbl [MAX_FRAMES];
  logic                 valid_tbl [MAX_FRAMES];
  logic [AGE_W-1:0]     age_tbl [MAX_FRAMES];
  logic [FAULT_W-1:0]   miss_cnt;
  logic [CFG_W-1:0]     frames_cfg;

  logic [PAGE_BITS-1:0] page_queue [$];
  page_result_t         expected_refs [$];

  bit item_accepted;
  bit no_gaps;
  int gap_left;
  int burst_left;
  int mismatches;
  int refs_checked;
  int hits_seen;
  int evictions_seen;
  int settings_run;
  int idle_cycles;

  function automatic void clear_frames();
    for (int i = 0; i < MAX_FRAMES; i++) begin
      page_tbl[i]  = '0;
      valid_tbl[i] = 1'b0;
      age_tbl[i]   = '0;
    end
    miss_cnt   = '0;
    frames_cfg = CFG_RESET;
  endfunction

  // make frame f the youngest; all_valid ages every other valid frame
  function automatic void promote_frame(int n, int f, bit all_valid);
    logic [AGE_W-1:0] a;
    a = age_tbl[f];
    for (int i = 0; i < n; i++) begin
      if (i != f && valid_tbl[i] && (all_valid || age_tbl[i] < a)) begin
        if (age_tbl[i] != AGE_MAX) age_tbl[i] = age_tbl[i] + 1'b1;
      end
    end
    age_tbl[f] = '0;
  endfunction

  function automatic page_result_t lookup_page(logic [PAGE_BITS-1:0] pg);
    page_result_t     r;
    int               n;
    int               f;
    bit               found;
    logic [AGE_W-1:0] oldest;
    r = '0;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg));
    f = 0;
    found = 1'b0;
    for (int i = 0; i < n && !found; i++) begin
      if (valid_tbl[i] && page_tbl[i] == pg) begin
        f = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      promote_frame(n, f, 1'b0);
    end else begin
      if (miss_cnt != '1) miss_cnt = miss_cnt + 1'b1;
      for (int i = 0; i < n && !found; i++) begin
        if (!valid_tbl[i]) begin
          f = i;
          found = 1'b1;
        end
      end
      if (found) begin
        valid_tbl[f] = 1'b1;
        page_tbl[f]  = pg;
        age_tbl[f]   = '0;
        promote_frame(n, f, 1'b1);
      end else begin
        // oldest frame goes, lowest index on ties
        oldest = '0;
        f = 0;
        for (int i = 0; i < n; i++) begin
          if (age_tbl[i] > oldest) begin
            oldest = age_tbl[i];
            f = i;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = page_tbl[f];
        promote_frame(n, f, 1'b0);
        page_tbl[f] = pg;
      end
    end
    r.frame  = IDX_W'(f);
    r.faults = miss_cnt;
    return r;
  endfunction

  // driver: bursts of items with random gaps, inputs move on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_accepted) begin
      // hold the item until the block takes it
    end else if (gap_left != 0) begin
      gap_left--;
      start <= 1'b0;
      page_number <= PAGE_BITS'($urandom);
    end else if (page_queue.size() != 0) begin
      page_number <= page_queue.pop_front();
      start <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 7) == 0) begin
          burst_left = 40;
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
        if (no_gaps) gap_left = 0;
      end
    end else begin
      start <= 1'b0;
      page_number <= PAGE_BITS'($urandom);
    end
  end

  // monitor: results, accepted items, register accesses, watchdog
  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    bit           activity;
    if (rst) begin
      clear_frames();
      expected_refs.delete();
      item_accepted = 1'b0;
      idle_cycles = 0;
    end else begin
      activity = 1'b0;
      if (done) begin
        activity = 1'b1;
        got = '{hit, frame_index, evicted_valid, evicted_page, fault_count};
        if (expected_refs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no item pending: %p", got);
        end else begin
          want = expected_refs.pop_front();
          refs_checked++;
          if (got.hit !== want.hit || got.frame !== want.frame
              || got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page
              || got.faults !== want.faults) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d/%h %0d, got %0d %0d %0d/%h %0d",
                       want.hit, want.frame, want.ev_valid, want.ev_page, want.faults,
                       got.hit, got.frame, got.ev_valid, got.ev_page, got.faults);
          end
        end
      end
      item_accepted = start && !busy;
      if (item_accepted) begin
        activity = 1'b1;
        want = lookup_page(page_number);
        if (want.hit) hits_seen++;
        if (want.ev_valid) evictions_seen++;
        expected_refs.push_back(want);
      end
      if (psel && penable) begin
        activity = 1'b1;
        if (paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE) begin
          if (pwrite && pready) begin
            frames_cfg = pwdata[CFG_W-1:0];
          end else if (!pwrite && prdata !== APB_DATA_W'(frames_cfg)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("register readback: expected %0d, got %0d", frames_cfg, prdata);
          end
        end
      end
      idle_cycles = activity ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no progress for %0d cycles", IDLE_LIMIT);
        $display("FAIL lru_page_replacement");
        $finish;
      end
    end
  end

  task automatic apb_access(bit wr, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frames(logic [APB_DATA_W-1:0] data);
    apb_access(1'b1, {REG_FRAMES_IN_USE, 2'b00}, data);
    apb_access(1'b0, {REG_FRAMES_IN_USE, 2'b00}, '0);
    settings_run++;
  endtask

  // wait until every item is through, then let the last update settle
  task automatic drain();
    while (page_queue.size() != 0 || start || expected_refs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // mostly a small working set so hits and evictions interleave, some noise
  task automatic queue_random(int count, int frames);
    logic [PAGE_BITS-1:0] pool [$];
    int                   pool_size;
    pool_size = $urandom_range(1, frames + 4);
    for (int i = 0; i < pool_size; i++) pool.push_back(PAGE_BITS'($urandom));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85)
        page_queue.push_back(pool[$urandom_range(0, pool_size - 1)]);
      else
        page_queue.push_back(PAGE_BITS'($urandom));
    end
  endtask

  initial begin
    logic [APB_DATA_W-1:0] settings [$];
    logic [CFG_W-1:0]      v;
    int                    frames;
    rst         = 1'b1;
    start       = 1'b0;
    page_number = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    no_gaps     = 1'b0;
    gap_left    = 0;
    burst_left  = 1;
    mismatches  = 0;
    refs_checked = 0;
    hits_seen   = 0;
    evictions_seen = 0;
    settings_run = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default four frames: fill, hit, evict, field extremes
    page_queue = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h1234,
                   16'h0001, 16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h8000,
                   16'h5555, 16'hAAAA, 16'h1234, 16'h0001, 16'h7FFF, 16'h7FFF};
    drain();
    queue_random(PHASE_ITEMS, 4);
    drain();

    // extremes, zero and oversize counts, upper data bits to be dropped
    settings = '{32'd1, 32'd16, 32'd0, 32'd31, 32'd2, 32'd7, 32'd17, 32'hFFFF_FFE3,
                 32'd12, 32'd5, 32'd16};
    foreach (settings[k]) begin
      set_frames(settings[k]);
      if (k == 4) apb_access(1'b1, 3'b100, 32'd9);
      v = settings[k][CFG_W-1:0];
      frames = (v == 0) ? 1 : ((v > MAX_FRAMES) ? MAX_FRAMES : int'(v));
      queue_random(PHASE_ITEMS, frames);
      drain();
    end

    // one frame and fresh pages back to back: every item misses and evicts
    set_frames(32'd1);
    no_gaps = 1'b1;
    for (int i = 0; i < MISS_ITEMS; i++) page_queue.push_back(PAGE_BITS'(i));
    drain();
    no_gaps = 1'b0;
    set_frames(32'd16);
    queue_random(PHASE_ITEMS, MAX_FRAMES);
    drain();

    $display("%0d page references checked over %0d frame settings", refs_checked,
             settings_run + 1);
    $display("%0d hits, %0d evictions, miss count ended at %0d", hits_seen, evictions_seen,
             miss_cnt);
    if (mismatches == 0 && expected_refs.size() == 0) begin
      $display("PASS lru_page_replacement");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_refs.size());
      $display("FAIL lru_page_replacement");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lru_pkg.sv
hw/rtl/lru_cell.sv
hw/rtl/lru_page_replacement.sv
verif/tb_lru_page_replacement.sv
